// ===== hw/rtl/tsag_pkg.sv =====
// Package with shared constants and types for the transpose source address generator.
package tsag_pkg;

  localparam int MAX_RANK_DEF    = 8;
  localparam int EXTENT_BITS_DEF = 8;
  localparam int INDEX_BITS_DEF  = 32;

  localparam int DEST_W    = 32;
  localparam int SRC_W     = 32;
  localparam int RANK_W    = 4;
  localparam int EXTENTS_W = 64;
  localparam int ORDER_W   = 24;
  localparam int AXIS_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;
  localparam int DIGITS    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RANK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENTS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER   = 2'd2;

  typedef struct packed {
    logic valid;
    logic in_range;
    logic bad;
  } tsag_ctl_t;

  typedef struct packed {
    logic busy;
    logic bad;
  } tsag_status_t;

endpackage

// ===== hw/rtl/tsag_if.sv =====
// Channel interfaces for input, result and configuration transactions.
interface tsag_in_if import tsag_pkg::*;;
  logic              valid;
  logic              ready;
  logic [DEST_W-1:0] dest_index;
  modport source(output valid, output dest_index, input ready);
  modport sink(input valid, input dest_index, output ready);
endinterface

interface tsag_out_if import tsag_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SRC_W-1:0] source_index;
  logic             in_range;
  logic             bad_config;
  modport source(output valid, output source_index, output in_range, output bad_config,
                 input ready);
  modport sink(input valid, input source_index, input in_range, input bad_config,
               output ready);
endinterface

interface tsag_cfg_if import tsag_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/transpose_source_address_generator.sv =====
// Top level of the transpose source address generator: a chain of division and stride cells.
// Throughput is one transaction per cycle unless the output stalls or a stride pass runs.
// Each division cell resolves up to four quotient bits of one destination axis.
// After reset and after each configuration write, a stride pass over all axes holds input off.
// Reset is synchronous and active low and restores the default configuration.
module transpose_source_address_generator import tsag_pkg::*; #(
  parameter int MAX_RANK    = MAX_RANK_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tsag_in_if.sink    in_ch,
  tsag_out_if.source out_ch,
  tsag_cfg_if.sink   cfg_ch
);

  localparam int NS = (INDEX_BITS + DIGITS - 1) / DIGITS;
  localparam int G  = NS + 1;
  localparam int T  = MAX_RANK * G;

  logic [EXTENT_BITS-1:0] pos_div [MAX_RANK];
  logic [INDEX_BITS-1:0]  pos_stride [MAX_RANK];
  logic [INDEX_BITS:0]    count;
  tsag_status_t           status;

  tsag_ctl_t              ctl [T+1];
  logic [EXTENT_BITS-1:0] rem [T+1];
  logic [INDEX_BITS-1:0]  num [T+1];
  logic [INDEX_BITS-1:0]  src [T+1];

  logic                  en;
  logic [INDEX_BITS-1:0] dest_w;

  tsag_cfg #(
    .MAX_RANK(MAX_RANK), .EXTENT_BITS(EXTENT_BITS), .INDEX_BITS(INDEX_BITS)
  ) u_cfg (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_ch),
    .pos_div_o(pos_div), .pos_stride_o(pos_stride),
    .count_o(count), .status_o(status)
  );

  assign en          = !ctl[T].valid || out_ch.ready;
  assign in_ch.ready = en && !status.busy;
  assign dest_w      = INDEX_BITS'(in_ch.dest_index);

  assign ctl[0].valid    = in_ch.valid && in_ch.ready;
  assign ctl[0].in_range = {1'b0, dest_w} < count;
  assign ctl[0].bad      = status.bad;
  assign rem[0]          = '0;
  assign num[0]          = dest_w;
  assign src[0]          = '0;

  for (genvar t = 0; t < T; t++) begin : g_cell
    localparam int GI  = t / G;
    localparam int J   = t % G;
    localparam int POS = MAX_RANK - 1 - GI;
    if (J < NS) begin : g_div
      localparam int STEPS = (J == NS - 1) ? (INDEX_BITS - (NS - 1) * DIGITS) : DIGITS;
      tsag_div_cell #(
        .EXTENT_BITS(EXTENT_BITS), .INDEX_BITS(INDEX_BITS), .STEPS(STEPS)
      ) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .divisor(pos_div[POS]),
        .ctl_i(ctl[t]), .rem_i(rem[t]), .num_i(num[t]), .src_i(src[t]),
        .ctl_o(ctl[t+1]), .rem_o(rem[t+1]), .num_o(num[t+1]), .src_o(src[t+1])
      );
    end else begin : g_mac
      tsag_mac_cell #(
        .EXTENT_BITS(EXTENT_BITS), .INDEX_BITS(INDEX_BITS)
      ) u_mac (
        .clk(clk), .rst_n(rst_n), .en(en), .stride(pos_stride[POS]),
        .ctl_i(ctl[t]), .rem_i(rem[t]), .num_i(num[t]), .src_i(src[t]),
        .ctl_o(ctl[t+1]), .rem_o(rem[t+1]), .num_o(num[t+1]), .src_o(src[t+1])
      );
    end
  end

  assign out_ch.valid        = ctl[T].valid;
  assign out_ch.bad_config   = ctl[T].bad;
  assign out_ch.in_range     = ctl[T].in_range && !ctl[T].bad;
  assign out_ch.source_index = (ctl[T].in_range && !ctl[T].bad) ? SRC_W'(src[T]) : '0;

endmodule

// ===== hw/rtl/tsag_cfg.sv =====
// Configuration registers and the sequencer that derives strides and element count.
module tsag_cfg import tsag_pkg::*; #(
  parameter int MAX_RANK    = MAX_RANK_DEF,
  parameter int EXTENT_BITS = EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tsag_cfg_if.sink               cfg,
  output logic [EXTENT_BITS-1:0] pos_div_o [MAX_RANK],
  output logic [INDEX_BITS-1:0]  pos_stride_o [MAX_RANK],
  output logic [INDEX_BITS:0]    count_o,
  output tsag_status_t           status_o
);

  localparam int KW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam logic [INDEX_BITS:0] CAP = {1'b1, {INDEX_BITS{1'b0}}};

  logic [RANK_W-1:0]     rank_r;
  logic [EXTENTS_W-1:0]  ext_r;
  logic [ORDER_W-1:0]    ord_r;
  logic                  busy_r;
  logic                  bad_r;
  logic [KW-1:0]         k_r;
  logic [INDEX_BITS-1:0] acc_r;
  logic [INDEX_BITS:0]   cnt_r;
  logic [INDEX_BITS-1:0] stride_r [MAX_RANK];

  logic                           bad_c;
  logic [EXTENT_BITS-1:0]         ek;
  logic [INDEX_BITS+EXTENT_BITS:0] cnt_prod;

  assign cfg.ready = 1'b1;

  always_comb begin
    bad_c = (rank_r == '0) || (rank_r > RANK_W'(MAX_RANK));
    for (int i = 0; i < MAX_RANK; i++) begin
      if (RANK_W'(i) < rank_r) begin
        if (ext_r[i*EXTENT_BITS +: EXTENT_BITS] == '0) bad_c = 1'b1;
        if (RANK_W'(ord_r[i*AXIS_W +: AXIS_W]) >= rank_r) bad_c = 1'b1;
        for (int j = 0; j < i; j++) begin
          if (ord_r[i*AXIS_W +: AXIS_W] == ord_r[j*AXIS_W +: AXIS_W]) bad_c = 1'b1;
        end
      end
    end
  end

  assign ek       = ext_r[k_r*EXTENT_BITS +: EXTENT_BITS];
  assign cnt_prod = (INDEX_BITS+EXTENT_BITS+1)'(cnt_r) * (INDEX_BITS+EXTENT_BITS+1)'(ek);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_W'(1);
      ext_r  <= EXTENTS_W'(1);
      ord_r  <= '0;
      busy_r <= 1'b1;
      bad_r  <= 1'b0;
      k_r    <= KW'(MAX_RANK - 1);
      acc_r  <= INDEX_BITS'(1);
      cnt_r  <= (INDEX_BITS+1)'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_RANK:    rank_r <= cfg.data[RANK_W-1:0];
        CFG_EXTENTS: ext_r  <= cfg.data[EXTENTS_W-1:0];
        CFG_ORDER:   ord_r  <= cfg.data[ORDER_W-1:0];
        default:     ;
      endcase
      busy_r <= 1'b1;
      k_r    <= KW'(MAX_RANK - 1);
      acc_r  <= INDEX_BITS'(1);
      cnt_r  <= (INDEX_BITS+1)'(1);
    end else if (busy_r) begin
      if (RANK_W'(k_r) < rank_r) begin
        acc_r <= INDEX_BITS'(acc_r * INDEX_BITS'(ek));
        cnt_r <= (cnt_prod > (INDEX_BITS+EXTENT_BITS+1)'(CAP)) ? CAP : cnt_prod[INDEX_BITS:0];
      end
      bad_r <= bad_c;
      if (k_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        k_r <= k_r - KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      stride_r[k_r] <= acc_r;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RANK; i++) begin
      logic [AXIS_W-1:0] a;
      a = ord_r[i*AXIS_W +: AXIS_W];
      if ((RANK_W'(i) < rank_r) && (int'(a) < MAX_RANK)) begin
        pos_div_o[i]    = ext_r[a*EXTENT_BITS +: EXTENT_BITS];
        pos_stride_o[i] = stride_r[a[KW-1:0]];
      end else begin
        pos_div_o[i]    = EXTENT_BITS'(1);
        pos_stride_o[i] = '0;
      end
    end
  end

  assign count_o       = cnt_r;
  assign status_o.busy = busy_r;
  assign status_o.bad  = bad_r;

endmodule

// ===== hw/rtl/tsag_div_cell.sv =====
// Cell that performs STEPS restoring division steps by one axis extent.
module tsag_div_cell import tsag_pkg::*; #(
  parameter int EXTENT_BITS = EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF,
  parameter int STEPS       = DIGITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [EXTENT_BITS-1:0] divisor,
  input  tsag_ctl_t              ctl_i,
  input  logic [EXTENT_BITS-1:0] rem_i,
  input  logic [INDEX_BITS-1:0]  num_i,
  input  logic [INDEX_BITS-1:0]  src_i,
  output tsag_ctl_t              ctl_o,
  output logic [EXTENT_BITS-1:0] rem_o,
  output logic [INDEX_BITS-1:0]  num_o,
  output logic [INDEX_BITS-1:0]  src_o
);

  tsag_ctl_t              ctl_r;
  logic [EXTENT_BITS-1:0] rem_r, rem_nxt;
  logic [INDEX_BITS-1:0]  num_r, num_nxt, src_r;
  logic [EXTENT_BITS:0]   rem_x;

  always_comb begin
    rem_nxt = rem_i;
    num_nxt = num_i;
    rem_x   = '0;
    for (int j = 0; j < STEPS; j++) begin
      rem_x   = {rem_nxt, num_nxt[INDEX_BITS-1]};
      num_nxt = {num_nxt[INDEX_BITS-2:0], 1'b0};
      if (rem_x >= {1'b0, divisor}) begin
        rem_x      = rem_x - {1'b0, divisor};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = rem_x[EXTENT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      src_r <= src_i;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign num_o = num_r;
  assign src_o = src_r;

endmodule

// ===== hw/rtl/tsag_mac_cell.sv =====
// Cell that adds one coordinate times its source stride to the running source index.
module tsag_mac_cell import tsag_pkg::*; #(
  parameter int EXTENT_BITS = EXTENT_BITS_DEF,
  parameter int INDEX_BITS  = INDEX_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [INDEX_BITS-1:0]  stride,
  input  tsag_ctl_t              ctl_i,
  input  logic [EXTENT_BITS-1:0] rem_i,
  input  logic [INDEX_BITS-1:0]  num_i,
  input  logic [INDEX_BITS-1:0]  src_i,
  output tsag_ctl_t              ctl_o,
  output logic [EXTENT_BITS-1:0] rem_o,
  output logic [INDEX_BITS-1:0]  num_o,
  output logic [INDEX_BITS-1:0]  src_o
);

  tsag_ctl_t             ctl_r;
  logic [INDEX_BITS-1:0] num_r, src_r, src_nxt;

  assign src_nxt = src_i + INDEX_BITS'(stride * INDEX_BITS'(rem_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_i;
      src_r <= src_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = '0;
  assign num_o = num_r;
  assign src_o = src_r;

endmodule
